// ===== rtl/pulse_rate_gauge_driver_top_defines.svh =====
// ----------------------------------------------------------------------------
// pulse_rate_gauge_driver_top_defines.svh
// Assertion macros shared by the gauge driver checker.
// ----------------------------------------------------------------------------
`ifndef PULSE_RATE_GAUGE_DRIVER_TOP_DEFINES_SVH
`define PULSE_RATE_GAUGE_DRIVER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define PRGD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prgd_pkg.sv =====
// ----------------------------------------------------------------------------
// prgd_pkg
// Types and constants for the pulse rate gauge driver.
// ----------------------------------------------------------------------------
`default_nettype none

package prgd_pkg;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [7:0]  SPEED_LIMIT = 8'd150;
    localparam logic [11:0] RPM_LIMIT   = 12'd3000;
    localparam logic [11:0] RPM_HALF    = 12'd1500;
    localparam logic [7:0]  DUTY_SPAN   = 8'd50;
    localparam logic [7:0]  DUTY_TOP    = 8'd255;

    // floor(x/150) = (x * RECIP_150) >> 24 for x < 2^16
    localparam logic [16:0] RECIP_150 = 17'd111849;
    // floor(x/30) = (x * RECIP_30) >> 16 for x <= 1500
    localparam logic [11:0] RECIP_30  = 12'd2185;

    localparam logic [7:0]  RST_ANGLE_ZERO  = 8'd143;
    localparam logic [7:0]  RST_ANGLE_FULL  = 8'd14;
    localparam logic [7:0]  RST_SLEW_STEP   = 8'd7;
    localparam logic [9:0]  RST_UPD_INTV    = 10'd20;
    localparam logic [15:0] RST_SPD_TIMEOUT = 16'd300;
    localparam logic [15:0] RST_RPM_TIMEOUT = 16'd600;
    localparam logic [15:0] RST_SPD_SCALE   = 16'd6800;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ANGLE_ZERO,
        CFG_ANGLE_FULL,
        CFG_SLEW_STEP,
        CFG_UPD_INTV,
        CFG_SPD_TIMEOUT,
        CFG_RPM_TIMEOUT,
        CFG_SPD_SCALE
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPD,
        S_SPD_DIV,
        S_SPD_TO,
        S_SRV,
        S_SRV_MUL,
        S_SRV_STEP,
        S_RPM,
        S_RPM_DIV,
        S_RPM_TO,
        S_DUTY
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

// ===== rtl/prgd_div.sv =====
// ----------------------------------------------------------------------------
// prgd_div
// Restoring divider, one quotient bit per cycle, shared by speed and rpm.
// ----------------------------------------------------------------------------
`default_nettype none

module prgd_div import prgd_pkg::*; #(
    parameter int DW = 16,
    parameter int VW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic      [DW-1:0] o_quotient,
    output t_div_sts           o_sts
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          fits;

    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign fits    = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

// ===== rtl/pulse_rate_gauge_driver_top.sv =====
// Flow: a sample walks S_SPD, S_SPD_DIV (speed group), S_SPD_TO, S_SRV,
//   S_SRV_MUL and S_SRV_STEP (servo update), S_RPM, S_RPM_DIV (rpm group),
//   S_RPM_TO and S_DUTY, one sample at a time; input not ready while a
//   sample is worked or its result waits on a stalled output.
// Reset: synchronous active-low; clears time, counters and held values,
//   loads register defaults; first result follows the first sample.
// ----------------------------------------------------------------------------
// pulse_rate_gauge_driver_top
// Pulse-period tachometer: rpm gauge duty/direction and slewed speed servo.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_rate_gauge_driver_top import prgd_pkg::*; #(
    parameter int SPEED_EDGES_PER_GROUP = 76,
    parameter int RPM_EDGES_PER_GROUP   = 5,
    parameter int RPM_PER_EDGE_SCALE    = 3000,
    parameter int TIME_BITS             = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CFG_IW-1:0]   i_cfg_index,
    input  wire logic [CFG_DW-1:0]   i_cfg_data,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // [0] ms_tick, [1] rpm_edge, [2] speed_edge, [7:3] zero
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // [0] rpm_direction, [8:1] rpm_duty, [16:9] servo_angle,
    // [24:17] speed_value, [36:25] rpm_value, [39:37] zero
    output logic [M_DATA_W-1:0]      o_m_tdata
);

    localparam int SCW     = $clog2(SPEED_EDGES_PER_GROUP + 1);
    localparam int RCW     = $clog2(RPM_EDGES_PER_GROUP + 1);
    localparam int RPM_NUM = RPM_EDGES_PER_GROUP * RPM_PER_EDGE_SCALE;
    localparam int NUM_W   = $clog2(RPM_NUM + 1);
    localparam int DW      = (NUM_W > CFG_DW) ? NUM_W : CFG_DW;

    localparam logic [SCW-1:0] SPD_N   = SCW'(SPEED_EDGES_PER_GROUP);
    localparam logic [RCW-1:0] RPM_N   = RCW'(RPM_EDGES_PER_GROUP);
    localparam logic [DW-1:0]  RPM_DVD = DW'(RPM_NUM);

    t_state r_state, n_state;

    logic [7:0]           r_a0, r_a1, r_slew;
    logic [9:0]           r_intv;
    logic [15:0]          r_spd_to, r_rpm_to, r_spd_scale;

    logic [TIME_BITS-1:0] r_now, r_last_spd, r_last_rpm, r_last_srv;
    logic [SCW-1:0]       r_spd_cnt;
    logic [RCW-1:0]       r_rpm_cnt;
    logic                 r_spd_grp, r_rpm_grp;
    logic [7:0]           r_speed, r_angle;
    logic [11:0]          r_rpm;
    logic                 r_prod_neg;
    logic [15:0]          r_prod_mag;
    logic [7:0]           r_tq;
    logic                 r_out_valid;
    logic [M_DATA_W-1:0]  r_out_data;

    logic [TIME_BITS-1:0] el_base, el;
    logic                 el_zero;
    logic                 div_start;
    logic [DW-1:0]        div_dividend, div_quo;
    t_div_sts             div_sts;
    logic                 out_free;

    logic [SCW-1:0]       spd_cnt_inc;
    logic [RCW-1:0]       rpm_cnt_inc;
    logic signed [8:0]    a_diff;
    logic signed [17:0]   prod, prod_abs;
    logic [32:0]          q150_full;
    logic signed [10:0]   tgt, adiff, step_s, ang_s, ang_new;
    logic                 rpm_hi;
    logic [10:0]          duty_x;
    logic [22:0]          q30_full;
    logic [7:0]           duty;

    assign el       = r_now - el_base;
    assign el_zero  = (el == '0);
    assign out_free = !r_out_valid || i_m_tready;

    assign div_dividend = (r_state == S_RPM) ? RPM_DVD : DW'(r_spd_scale);

    prgd_div #(
        .DW (DW),
        .VW (TIME_BITS)
    ) u_prgd_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (el),
        .o_quotient (div_quo),
        .o_sts      (div_sts)
    );

    always_comb begin
        if (r_state == S_SRV) begin
            el_base = r_last_srv;
        end else if (r_state inside {S_RPM, S_RPM_DIV, S_RPM_TO}) begin
            el_base = r_last_rpm;
        end else begin
            el_base = r_last_spd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && !div_sts.busy) begin
                    n_state = S_SPD;
                end
            end
            S_SPD: begin
                if (r_spd_grp && !el_zero) begin
                    div_start = 1'b1;
                    n_state   = S_SPD_DIV;
                end else begin
                    n_state = S_SPD_TO;
                end
            end
            S_SPD_DIV: begin
                if (div_sts.done) begin
                    n_state = S_SPD_TO;
                end
            end
            S_SPD_TO: n_state = S_SRV;
            S_SRV: begin
                n_state = (el >= TIME_BITS'(r_intv)) ? S_SRV_MUL : S_RPM;
            end
            S_SRV_MUL:  n_state = S_SRV_STEP;
            S_SRV_STEP: n_state = S_RPM;
            S_RPM: begin
                if (r_rpm_grp && !el_zero) begin
                    div_start = 1'b1;
                    n_state   = S_RPM_DIV;
                end else begin
                    n_state = S_RPM_TO;
                end
            end
            S_RPM_DIV: begin
                if (div_sts.done) begin
                    n_state = S_RPM_TO;
                end
            end
            S_RPM_TO: begin
                n_state = S_DUTY;
            end
            S_DUTY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign spd_cnt_inc = r_spd_cnt + 1'b1;
    assign rpm_cnt_inc = r_rpm_cnt + 1'b1;

    // target = a0 + trunc(speed * (a1 - a0) / 150)
    assign a_diff    = $signed({1'b0, r_a1}) - $signed({1'b0, r_a0});
    assign prod      = $signed({1'b0, r_speed}) * a_diff;
    assign prod_abs  = prod[17] ? (18'sd0 - prod) : prod;
    assign q150_full = 33'(r_prod_mag) * 33'(RECIP_150);

    assign ang_s  = $signed({3'b000, r_angle});
    assign step_s = $signed({3'b000, r_slew});
    assign tgt    = r_prod_neg ? ($signed({3'b000, r_a0}) - $signed({3'b000, r_tq}))
                               : ($signed({3'b000, r_a0}) + $signed({3'b000, r_tq}));
    assign adiff  = tgt - ang_s;

    always_comb begin
        if (adiff > step_s) begin
            ang_new = ang_s + step_s;
        end else if (adiff < -step_s) begin
            ang_new = ang_s - step_s;
        end else begin
            ang_new = tgt;
        end
    end

    // duty = base - x/30
    assign rpm_hi   = (r_rpm > RPM_HALF);
    assign duty_x   = rpm_hi ? 11'(r_rpm - RPM_HALF) : r_rpm[10:0];
    assign q30_full = 23'(duty_x) * 23'(RECIP_30);
    assign duty     = (rpm_hi ? DUTY_TOP : DUTY_SPAN) - {1'b0, q30_full[22:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0        <= RST_ANGLE_ZERO;
            r_a1        <= RST_ANGLE_FULL;
            r_slew      <= RST_SLEW_STEP;
            r_intv      <= RST_UPD_INTV;
            r_spd_to    <= RST_SPD_TIMEOUT;
            r_rpm_to    <= RST_RPM_TIMEOUT;
            r_spd_scale <= RST_SPD_SCALE;
            r_now       <= '0;
            r_last_spd  <= '0;
            r_last_rpm  <= '0;
            r_last_srv  <= '0;
            r_spd_cnt   <= '0;
            r_rpm_cnt   <= '0;
            r_spd_grp   <= 1'b0;
            r_rpm_grp   <= 1'b0;
            r_speed     <= '0;
            r_angle     <= '0;
            r_rpm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ANGLE_ZERO:  r_a0        <= i_cfg_data[7:0];
                    CFG_ANGLE_FULL:  r_a1        <= i_cfg_data[7:0];
                    CFG_SLEW_STEP:   r_slew      <= i_cfg_data[7:0];
                    CFG_UPD_INTV:    r_intv      <= i_cfg_data[9:0];
                    CFG_SPD_TIMEOUT: r_spd_to    <= i_cfg_data;
                    CFG_RPM_TIMEOUT: r_rpm_to    <= i_cfg_data;
                    CFG_SPD_SCALE:   r_spd_scale <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_DUTY && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && !div_sts.busy) begin
                        if (i_s_tdata[0]) begin
                            r_now <= r_now + 1'b1;
                        end
                        r_spd_grp <= i_s_tdata[2] && (spd_cnt_inc >= SPD_N);
                        if (i_s_tdata[2]) begin
                            if (spd_cnt_inc >= SPD_N) begin
                                r_spd_cnt <= '0;
                            end else begin
                                r_spd_cnt <= spd_cnt_inc;
                            end
                        end
                        r_rpm_grp <= i_s_tdata[1] && (rpm_cnt_inc >= RPM_N);
                        if (i_s_tdata[1]) begin
                            if (rpm_cnt_inc >= RPM_N) begin
                                r_rpm_cnt <= '0;
                            end else begin
                                r_rpm_cnt <= rpm_cnt_inc;
                            end
                        end
                    end
                end
                S_SPD: begin
                    if (r_spd_grp && el_zero) begin
                        r_speed    <= SPEED_LIMIT;
                        r_last_spd <= r_now;
                    end
                end
                S_SPD_DIV: begin
                    if (div_sts.done) begin
                        r_speed    <= (div_quo > DW'(SPEED_LIMIT)) ? SPEED_LIMIT : div_quo[7:0];
                        r_last_spd <= r_now;
                    end
                end
                S_SPD_TO: begin
                    if (el > TIME_BITS'(r_spd_to)) begin
                        r_speed <= '0;
                    end
                end
                S_SRV: begin
                    if (el >= TIME_BITS'(r_intv)) begin
                        r_last_srv <= r_now;
                    end
                end
                S_SRV_STEP: r_angle <= ang_new[7:0];
                S_RPM: begin
                    if (r_rpm_grp && el_zero) begin
                        r_rpm      <= RPM_LIMIT;
                        r_last_rpm <= r_now;
                    end
                end
                S_RPM_DIV: begin
                    if (div_sts.done) begin
                        r_rpm      <= (div_quo > DW'(RPM_LIMIT)) ? RPM_LIMIT : div_quo[11:0];
                        r_last_rpm <= r_now;
                    end
                end
                S_RPM_TO: begin
                    if (el > TIME_BITS'(r_rpm_to)) begin
                        r_rpm <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SRV) begin
            r_prod_neg <= prod[17];
            r_prod_mag <= prod_abs[15:0];
        end
        if (r_state == S_SRV_MUL) begin
            r_tq <= q150_full[31:24];
        end
        if (r_state == S_DUTY && out_free) begin
            r_out_data <= {3'b000, r_rpm, r_speed, r_angle, duty, rpm_hi};
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && !div_sts.busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/prgd_checker.sv =====
// ----------------------------------------------------------------------------
// prgd_checker
// Port-level checks on the gauge driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_rate_gauge_driver_top_defines.svh"

module prgd_checker import prgd_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_tvalid,
    input wire logic                o_s_tready,
    input wire logic                o_m_tvalid,
    input wire logic                i_m_tready,
    input wire logic [M_DATA_W-1:0] o_m_tdata
);

    `PRGD_ASSERT(a_speed_range, o_m_tvalid, o_m_tdata[24:17] <= SPEED_LIMIT, "speed out of range")

    `PRGD_ASSERT(a_rpm_dir, o_m_tvalid, (o_m_tdata[36:25] <= RPM_LIMIT) && (o_m_tdata[0] == (o_m_tdata[36:25] > RPM_HALF)), "rpm or direction inconsistent")

    `PRGD_ASSERT_NEXT(a_busy_after_in, i_s_tvalid && o_s_tready, !o_s_tready, "ready held after input transaction")

    `PRGD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

endmodule

bind pulse_rate_gauge_driver_top prgd_checker u_prgd_checker (.*);

`default_nettype wire

// ===== tb/pulse_rate_gauge_driver_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_rate_gauge_driver_top_tb
// Streams millisecond-tick and sensor-edge samples into the gauge driver and
// checks every gauge result against an in-bench tachometer/servo predictor.
// Runs several register settings, with random bursts and stalls on both sides.
// ----------------------------------------------------------------------------
module pulse_rate_gauge_driver_top_tb;
    import prgd_pkg::*;

    localparam int SPD_EDGES     = 76;
    localparam int RPM_EDGES     = 5;
    localparam int RPM_SCALE     = 3000;
    localparam int TBITS         = 32;
    localparam int WDOG_LIMIT    = 3000;
    localparam int CFG_SETTLE    = 12;
    localparam int END_SETTLE    = 60;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic [2:0]  pad;
        logic [11:0] rpm;
        logic [7:0]  speed;
        logic [7:0]  angle;
        logic [7:0]  duty;
        logic        dir;
    } t_gauge;

    typedef struct packed {
        logic speed_edge;
        logic rpm_edge;
        logic ms_tick;
    } t_sample;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PATTERN,
        RDY_SPARSE
    } t_rdy_mode;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data  = '0;
    logic                i_s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0] i_s_tdata   = '0;
    logic                i_m_tready  = 1'b0;
    wire                 o_s_tready;
    wire                 o_m_tvalid;
    wire  [M_DATA_W-1:0] o_m_tdata;

    pulse_rate_gauge_driver_top #(
        .SPEED_EDGES_PER_GROUP (SPD_EDGES),
        .RPM_EDGES_PER_GROUP   (RPM_EDGES),
        .RPM_PER_EDGE_SCALE    (RPM_SCALE),
        .TIME_BITS             (TBITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor registers and state
    logic [7:0]       a_zero    = RST_ANGLE_ZERO;
    logic [7:0]       a_full    = RST_ANGLE_FULL;
    logic [7:0]       slew      = RST_SLEW_STEP;
    logic [9:0]       upd_intv  = RST_UPD_INTV;
    logic [15:0]      spd_to    = RST_SPD_TIMEOUT;
    logic [15:0]      rpm_to    = RST_RPM_TIMEOUT;
    logic [15:0]      spd_scale = RST_SPD_SCALE;

    logic [TBITS-1:0] now_ms     = '0;
    logic [TBITS-1:0] spd_mark   = '0;
    logic [TBITS-1:0] rpm_mark   = '0;
    logic [TBITS-1:0] srv_mark   = '0;
    int               spd_cnt    = 0;
    int               rpm_cnt    = 0;
    logic [7:0]       speed_held = '0;
    logic [7:0]       angle_held = '0;
    logic [11:0]      rpm_held   = '0;

    t_sample sample_q[$];
    t_gauge  gauge_expect_q[$];

    int n_errors     = 0;
    int n_samples    = 0;
    int n_results    = 0;
    int n_spd_groups = 0;
    int n_rpm_groups = 0;
    int n_saturated  = 0;
    int n_timeouts   = 0;
    int n_servo_upd  = 0;

    logic      s_taken     = 1'b0;
    int        gap_left    = 0;
    int        burst_left  = 1;
    t_rdy_mode rdy_mode    = RDY_ALWAYS;
    int        rdy_left    = 40;
    logic [7:0] rdy_pattern = 8'hff;
    int        idle_cycles = 0;

    function automatic t_gauge gauge_advance(input t_sample s);
        logic [TBITS-1:0] period;
        logic [31:0]      v;
        logic             spd_done;
        logic             rpm_done;
        int               target;
        int               cur;
        int               diff;
        int               slew_amt;
        int               r;
        t_gauge           g;
        spd_done = 1'b0;
        rpm_done = 1'b0;
        g = '0;
        if (s.ms_tick) now_ms = now_ms + 1'b1;
        if (s.speed_edge) begin
            spd_cnt++;
            if (spd_cnt >= SPD_EDGES) begin
                spd_cnt = 0;
                spd_done = 1'b1;
            end
        end
        if (s.rpm_edge) begin
            rpm_cnt++;
            if (rpm_cnt >= RPM_EDGES) begin
                rpm_cnt = 0;
                rpm_done = 1'b1;
            end
        end

        if (spd_done) begin
            n_spd_groups++;
            period = now_ms - spd_mark;
            if (period == 0) n_saturated++;
            v = (period == 0) ? 32'(SPEED_LIMIT) : 32'(spd_scale) / period;
            spd_mark = now_ms;
            speed_held = (v > SPEED_LIMIT) ? SPEED_LIMIT : v[7:0];
        end
        if ((now_ms - spd_mark) > spd_to) begin
            if (speed_held != 0) n_timeouts++;
            speed_held = '0;
        end

        if ((now_ms - srv_mark) >= upd_intv) begin
            n_servo_upd++;
            target = int'(a_zero) +
                     (int'(speed_held) * (int'(a_full) - int'(a_zero))) / int'(SPEED_LIMIT);
            cur = int'(angle_held);
            diff = target - cur;
            slew_amt = int'(slew);
            srv_mark = now_ms;
            if (diff > slew_amt) cur = cur + slew_amt;
            else if (diff < -slew_amt) cur = cur - slew_amt;
            else cur = target;
            angle_held = cur[7:0];
        end

        if (rpm_done) begin
            n_rpm_groups++;
            period = now_ms - rpm_mark;
            if (period == 0) n_saturated++;
            v = (period == 0) ? 32'(RPM_LIMIT) : 32'(RPM_EDGES * RPM_SCALE) / period;
            rpm_mark = now_ms;
            rpm_held = (v > RPM_LIMIT) ? RPM_LIMIT : v[11:0];
        end
        if ((now_ms - rpm_mark) > rpm_to) begin
            if (rpm_held != 0) n_timeouts++;
            rpm_held = '0;
        end

        r = int'(rpm_held);
        if (rpm_held <= RPM_HALF) begin
            g.dir  = 1'b0;
            g.duty = 8'(int'(DUTY_SPAN) - (r * int'(DUTY_SPAN)) / int'(RPM_HALF));
        end else begin
            g.dir  = 1'b1;
            g.duty = 8'(int'(DUTY_TOP) -
                        ((r - int'(RPM_HALF)) * int'(DUTY_SPAN)) / int'(RPM_HALF));
        end
        g.angle = angle_held;
        g.speed = speed_held;
        g.rpm   = rpm_held;
        return g;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: result %0d %s expected %0d actual %0d",
                         $time, n_results, what, want, got);
        end
    endtask

    // sample driver: bursts with random gaps
    always @(negedge i_clk) begin : drive_samples
        t_sample nxt;
        logic    vld;
        vld = i_s_tvalid && !s_taken;
        nxt = t_sample'(i_s_tdata[2:0]);
        if (!vld && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (sample_q.size() > 0) begin
                nxt = sample_q.pop_front();
                vld = 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(30, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
        i_s_tvalid <= vld;
        i_s_tdata <= {5'b0, nxt};
    end

    // result-side backpressure
    always @(negedge i_clk) begin : drive_ready
        if (rdy_left == 0) begin
            rdy_mode <= t_rdy_mode'($urandom_range(3));
            rdy_left <= $urandom_range(80, 16);
            rdy_pattern <= 8'($urandom);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            RDY_ALWAYS:  i_m_tready <= 1'b1;
            RDY_COIN:    i_m_tready <= 1'($urandom_range(1));
            RDY_PATTERN: i_m_tready <= rdy_pattern[rdy_left % 8];
            default:     i_m_tready <= ($urandom_range(3) == 0);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_gauge got;
        t_gauge want;
        s_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_gauge'(o_m_tdata);
            if (gauge_expect_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result with none expected, actual %h", $time, o_m_tdata);
            end else begin
                want = gauge_expect_q.pop_front();
                check_field("rpm_direction", want.dir, got.dir);
                check_field("rpm_duty", want.duty, got.duty);
                check_field("servo_angle", want.angle, got.angle);
                check_field("speed_value", want.speed, got.speed);
                check_field("rpm_value", want.rpm, got.rpm);
            end
            n_results++;
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            gauge_expect_q.push_back(gauge_advance(t_sample'(i_s_tdata[2:0])));
            n_samples++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, gauge_expect_q.size());
            $display("pulse_rate_gauge_driver_top: mismatch");
            $finish;
        end
    end

    task automatic wait_idle(input int settle);
        do @(posedge i_clk);
        while (sample_q.size() != 0 || i_s_tvalid || gauge_expect_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ANGLE_ZERO:  a_zero = val[7:0];
            CFG_ANGLE_FULL:  a_full = val[7:0];
            CFG_SLEW_STEP:   slew = val[7:0];
            CFG_UPD_INTV:    upd_intv = val[9:0];
            CFG_SPD_TIMEOUT: spd_to = val;
            CFG_RPM_TIMEOUT: rpm_to = val;
            CFG_SPD_SCALE:   spd_scale = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_sample(input logic tick, input logic redge, input logic sedge);
        sample_q.push_back(t_sample'({sedge, redge, tick}));
    endtask

    task automatic run_random(input int n, input int p_tick, input int p_rpm, input int p_spd);
        for (int k = 0; k < n; k++)
            queue_sample($urandom_range(99) < p_tick, $urandom_range(99) < p_rpm,
                         $urandom_range(99) < p_spd);
        wait_idle(CFG_SETTLE);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty sample, same-ms rpm group (saturates), tick only,
        // 6 ms rpm group, then a 10 ms group landing on the half-scale boundary
        queue_sample(1'b0, 1'b0, 1'b0);
        repeat (5) queue_sample(1'b0, 1'b1, 1'b0);
        queue_sample(1'b1, 1'b0, 1'b0);
        repeat (5) queue_sample(1'b1, 1'b1, 1'b1);
        repeat (5) begin
            queue_sample(1'b1, 1'b0, 1'b1);
            queue_sample(1'b1, 1'b1, 1'b0);
        end
        wait_idle(CFG_SETTLE);

        run_random(300, 50, 40, 70);

        cfg_write(CFG_ANGLE_ZERO, 16'd0);
        cfg_write(CFG_ANGLE_FULL, 16'd180);
        cfg_write(CFG_SLEW_STEP, 16'd180);
        cfg_write(CFG_UPD_INTV, 16'd1);
        cfg_write(CFG_SPD_SCALE, 16'hffff);
        run_random(250, 60, 15, 80);

        cfg_write(CFG_ANGLE_ZERO, 16'd180);
        cfg_write(CFG_ANGLE_FULL, 16'd0);
        cfg_write(CFG_SLEW_STEP, 16'd1);
        cfg_write(CFG_UPD_INTV, 16'd1000);
        cfg_write(CFG_SPD_TIMEOUT, 16'd1);
        cfg_write(CFG_RPM_TIMEOUT, 16'd1);
        cfg_write(CFG_SPD_SCALE, 16'd1);
        run_random(200, 40, 50, 90);

        // sparse ticks: many same-ms groups; slew of zero freezes the angle
        cfg_write(CFG_SPD_TIMEOUT, 16'hffff);
        cfg_write(CFG_RPM_TIMEOUT, 16'hffff);
        cfg_write(CFG_UPD_INTV, 16'd0);
        cfg_write(CFG_SLEW_STEP, 16'd0);
        cfg_write(CFG_SPD_SCALE, 16'd6800);
        run_random(200, 5, 60, 90);

        cfg_write(CFG_ANGLE_ZERO, 16'd255);
        cfg_write(CFG_ANGLE_FULL, 16'd200);
        cfg_write(CFG_SLEW_STEP, 16'd3);
        cfg_write(CFG_UPD_INTV, 16'd5);
        cfg_write(CFG_SPD_TIMEOUT, 16'd40);
        cfg_write(CFG_RPM_TIMEOUT, 16'd30);
        cfg_write(CFG_SPD_SCALE, 16'd3000);
        run_random(250, 70, 90, 90);

        repeat (5) begin
            cfg_write(CFG_ANGLE_ZERO, 16'($urandom_range(180)));
            cfg_write(CFG_ANGLE_FULL, 16'($urandom_range(180)));
            cfg_write(CFG_SLEW_STEP, 16'($urandom_range(180, 1)));
            cfg_write(CFG_UPD_INTV, ($urandom_range(3) == 0) ?
                      16'($urandom_range(1000, 1)) : 16'($urandom_range(30, 1)));
            cfg_write(CFG_SPD_TIMEOUT, ($urandom_range(1) == 0) ?
                      16'($urandom_range(65535, 1)) : 16'($urandom_range(200, 1)));
            cfg_write(CFG_RPM_TIMEOUT, ($urandom_range(1) == 0) ?
                      16'($urandom_range(65535, 1)) : 16'($urandom_range(200, 1)));
            cfg_write(CFG_SPD_SCALE, 16'($urandom_range(65535, 1)));
            run_random(150, $urandom_range(90, 10), $urandom_range(90, 10),
                       $urandom_range(100, 30));
        end

        wait_idle(END_SETTLE);
        $display("%0d samples, %0d results; %0d speed and %0d rpm groups, %0d zero-period",
                 n_samples, n_results, n_spd_groups, n_rpm_groups, n_saturated);
        $display("%0d sensor timeouts, %0d servo updates over 10 register settings",
                 n_timeouts, n_servo_upd);
        if (n_errors == 0) begin
            $display("pulse_rate_gauge_driver_top: match");
        end else begin
            $display("pulse_rate_gauge_driver_top: mismatch");
        end
        $finish;
    end

endmodule
